// ===== sv/satcc_pkg.sv =====
// ----------------------------------------------------------------------------
// satcc_pkg
// Shared types and constants for the 3-literal clause checker: payload
// structs, the stored clause layout, opcodes, register indexes and the
// sequencer states.
// ----------------------------------------------------------------------------
package satcc_pkg;

  localparam int VAR_W   = 5;   // literal variable index
  localparam int SLOT_W  = 7;   // clause_slot field
  localparam int SOL_W   = 20;  // assignment / solution width
  localparam int CNT_W   = 8;   // clause_count / satisfied_count width
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // Opcodes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAUSE_COUNT = 1'b1;

  localparam logic [VAR_W-1:0] VAR_COUNT_RST    = 5'd20;
  localparam logic [CNT_W-1:0] CLAUSE_COUNT_RST = 8'd0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] clause_slot;
    logic [VAR_W-1:0]  var_first;
    logic [VAR_W-1:0]  var_second;
    logic [VAR_W-1:0]  var_third;
    logic              neg_first;
    logic              neg_second;
    logic              neg_third;
    logic [SOL_W-1:0]  assignment;
  } satcc_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] satisfied_count;
    logic             all_satisfied;
    logic [SOL_W-1:0] solution;
  } satcc_out_t;

  // Stored clause, 18 bits: var_first in the low bits, negation flags on top
  typedef struct packed {
    logic             neg_third;
    logic             neg_second;
    logic             neg_first;
    logic [VAR_W-1:0] var_third;
    logic [VAR_W-1:0] var_second;
    logic [VAR_W-1:0] var_first;
  } satcc_clause_t;

  localparam int CLAUSE_W = $bits(satcc_clause_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CHECK
  } satcc_state_t;

  // Bit v of the assignment; indexes at or above SOL_W read as zero
  function automatic logic lit_holds(logic [VAR_W-1:0] v, logic neg,
                                     logic [SOL_W-1:0] bits);
    logic [(1<<VAR_W)-1:0] ext;
    logic                  b;
    ext = {{((1<<VAR_W)-SOL_W){1'b0}}, bits};
    b   = ext[v];
    return b ^ neg;
  endfunction

  function automatic logic clause_holds(satcc_clause_t c, logic [SOL_W-1:0] bits);
    return lit_holds(c.var_first,  c.neg_first,  bits) |
           lit_holds(c.var_second, c.neg_second, bits) |
           lit_holds(c.var_third,  c.neg_third,  bits);
  endfunction

endpackage

// ===== sv/satcc_ram.sv =====
// ----------------------------------------------------------------------------
// satcc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module satcc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sat_clause_checker.sv =====
// ----------------------------------------------------------------------------
// sat_clause_checker
// 3-literal clause table with assignment evaluation and upward brute-force
// search for a fully satisfying mask.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------
//  input     start / busy          in_data  (satcc_in_t)
//  result    out_valid (1 cycle)   out_data (satcc_out_t)
//  config    cfg_we                cfg_index, cfg_wdata
//
//  Sequence: a load, an unused mode or a search that starts past range is
//  taken while idle, its beat appears the next cycle, and busy stays low.
//  An evaluation holds busy while the one clause-table read port issues
//  one read a cycle for each checked clause, each registered read returns
//  and is scored, the sweep drains and a check state ends it. Its beat
//  appears in the cycle busy drops. A search costs the same per mask tried.
//  Reset: synchronous, active low; clears the sequencer, the strobe and
//  the registers (var_count 20, clause_count 0). The table is not cleared.
//  Stalls: the receiver cannot stall; each result beat lasts one cycle.
// ----------------------------------------------------------------------------
module sat_clause_checker #(
  parameter int MAX_CLAUSE_SLOTS = 128,
  parameter int MAX_VARIABLES    = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  start,
  output logic                                  busy,
  input  satcc_pkg::satcc_in_t                  in_data,
  // result channel
  output logic                                  out_valid,
  output satcc_pkg::satcc_out_t                 out_data,
  // configuration
  input  logic                                  cfg_we,
  input  logic [satcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [satcc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW         = $clog2(MAX_CLAUSE_SLOTS);
  localparam int SLOTS      = 1 << satcc_pkg::SLOT_W;
  localparam int NC_CAP     = (MAX_CLAUSE_SLOTS < 255) ? MAX_CLAUSE_SLOTS : 255;
  localparam int VAR_CAP    = (MAX_VARIABLES < satcc_pkg::SOL_W) ?
                              MAX_VARIABLES : satcc_pkg::SOL_W;
  localparam int CLAUSE_W_L = satcc_pkg::CLAUSE_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [satcc_pkg::VAR_W-1:0] var_count_r;
  logic [satcc_pkg::CNT_W-1:0] clause_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r    <= satcc_pkg::VAR_COUNT_RST;
      clause_count_r <= satcc_pkg::CLAUSE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        satcc_pkg::CFG_VAR_COUNT:    var_count_r    <= cfg_wdata[satcc_pkg::VAR_W-1:0];
        satcc_pkg::CFG_CLAUSE_COUNT: clause_count_r <= cfg_wdata[satcc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective clause count (saturate at table depth) and search limit
  logic [satcc_pkg::CNT_W-1:0] nc_w;
  logic [satcc_pkg::VAR_W-1:0] ev_w;
  logic [satcc_pkg::SOL_W-1:0] limit_w;

  assign nc_w    = (clause_count_r > satcc_pkg::CNT_W'(NC_CAP)) ?
                   satcc_pkg::CNT_W'(NC_CAP) : clause_count_r;
  assign ev_w    = (var_count_r > satcc_pkg::VAR_W'(VAR_CAP)) ?
                   satcc_pkg::VAR_W'(VAR_CAP) : var_count_r;
  assign limit_w = satcc_pkg::SOL_W'(((satcc_pkg::SOL_W+1)'(1) << ev_w) -
                                     (satcc_pkg::SOL_W+1)'(1));

  // Slot fold: clause_slot modulo the table depth, as a constant table
  logic [AW-1:0] slot_map [SLOTS];
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    assign slot_map[i] = AW'(i % MAX_CLAUSE_SLOTS);
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  satcc_pkg::satcc_state_t       state_r, state_nxt;
  logic [satcc_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [satcc_pkg::SOL_W-1:0]   mask_r, mask_nxt;
  logic [satcc_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [satcc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic                          out_valid_r, out_valid_nxt;
  satcc_pkg::satcc_out_t         out_data_r, out_data_nxt;

  logic                    accept_w;
  logic                    issue_w;
  logic                    sweep_done_w;
  logic                    all_w;
  logic                    past_range_w;
  logic                    ram_we_w;
  satcc_pkg::satcc_clause_t ram_wdata_w;
  logic [CLAUSE_W_L-1:0]   ram_rdata_w;
  satcc_pkg::satcc_clause_t clause_w;

  assign busy         = (state_r != satcc_pkg::ST_IDLE);
  assign accept_w     = start && !busy;
  assign issue_w      = (state_r == satcc_pkg::ST_SWEEP) && (idx_r != nc_w);
  assign sweep_done_w = (idx_r == nc_w) && !rd_vld_r;
  assign all_w        = (cnt_r == nc_w);
  assign past_range_w = (in_data.assignment > limit_w);
  assign clause_w     = satcc_pkg::satcc_clause_t'(ram_rdata_w);

  assign ram_we_w = accept_w && (in_data.mode == satcc_pkg::MODE_LOAD);
  assign ram_wdata_w = '{neg_third:  in_data.neg_third,
                         neg_second: in_data.neg_second,
                         neg_first:  in_data.neg_first,
                         var_third:  in_data.var_third,
                         var_second: in_data.var_second,
                         var_first:  in_data.var_first};

  // Clause table: one write port for loads, one read port for the sweep
  satcc_ram #(
    .WIDTH (CLAUSE_W_L),
    .DEPTH (MAX_CLAUSE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we_w),
    .waddr (slot_map[in_data.clause_slot]),
    .wdata (ram_wdata_w),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata_w)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      satcc_pkg::ST_IDLE: begin
        if (accept_w) begin
          if (in_data.mode == satcc_pkg::MODE_EVAL) begin
            state_nxt = satcc_pkg::ST_SWEEP;
          end else if ((in_data.mode == satcc_pkg::MODE_SEARCH) && !past_range_w) begin
            state_nxt = satcc_pkg::ST_SWEEP;
          end
        end
      end
      satcc_pkg::ST_SWEEP: begin
        if (sweep_done_w) begin
          state_nxt = satcc_pkg::ST_CHECK;
        end
      end
      satcc_pkg::ST_CHECK: begin
        // Search retries the next mask unless it found one or hit the limit
        if ((mode_r == satcc_pkg::MODE_SEARCH) && !all_w && (mask_r != limit_w)) begin
          state_nxt = satcc_pkg::ST_SWEEP;
        end else begin
          state_nxt = satcc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = satcc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt      = mode_r;
    mask_nxt      = mask_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    case (state_r)
      satcc_pkg::ST_IDLE: begin
        if (accept_w) begin
          mode_nxt = in_data.mode;
          mask_nxt = in_data.assignment;
          idx_nxt  = '0;
          cnt_nxt  = '0;
          // Loads, unused modes and out-of-range starts answer with zeros now
          if (!((in_data.mode == satcc_pkg::MODE_EVAL) ||
                ((in_data.mode == satcc_pkg::MODE_SEARCH) && !past_range_w))) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      satcc_pkg::ST_SWEEP: begin
        // Issue one clause read a cycle; score it when the data returns
        rd_vld_nxt = issue_w;
        if (issue_w) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_vld_r && satcc_pkg::clause_holds(clause_w, mask_r)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      satcc_pkg::ST_CHECK: begin
        if (mode_r == satcc_pkg::MODE_EVAL) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.satisfied_count = cnt_r;
          out_data_nxt.all_satisfied   = all_w;
          out_data_nxt.solution        = mask_r;
        end else if (all_w) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.satisfied_count = cnt_r;
          out_data_nxt.all_satisfied   = 1'b1;
          out_data_nxt.solution        = mask_r;
        end else if (mask_r == limit_w) begin
          out_valid_nxt = 1'b1;  // not found: all zeros
        end else begin
          mask_nxt = mask_r + 1'b1;
          idx_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= satcc_pkg::ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The count never runs ahead of the reads that were issued
  a_cnt_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == satcc_pkg::ST_SWEEP) |-> (cnt_r <= idx_r))
    else $error("clause count exceeds issued reads");

  // The sweep never reads past the checked clauses
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == satcc_pkg::ST_SWEEP) |-> (idx_r <= nc_w))
    else $error("sweep index past clause count");

  // Read data returns only inside a sweep
  a_rd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == satcc_pkg::ST_SWEEP))
    else $error("read data outside sweep");

  // A reported full match carries the full clause count
  a_all_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.all_satisfied) |-> (out_data_r.satisfied_count == nc_w))
    else $error("all_satisfied without full count");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3-literal clause checker. A queue of pending
// beats and register writes feeds a falling-edge driver; a rising-edge
// monitor predicts each result from its own copy of the clause table and
// registers and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SLOTS       = 128;   // clause table depth
  localparam int          VAR_LIMIT   = 20;    // most variables a mask can hold
  localparam int          TAIL_CYCLES = 140;   // one full evaluation and then some
  localparam int          STALL_LIMIT = 20000; // cycles without any beat
  localparam int          SEARCH_COST = 1000;  // rough cycle budget per search
  localparam int          MODE_W      = satcc_pkg::MODE_W;
  localparam int          SOL_W       = satcc_pkg::SOL_W;
  localparam int          VAR_W       = satcc_pkg::VAR_W;
  localparam int          CNT_W       = satcc_pkg::CNT_W;
  localparam int          SLOT_W      = satcc_pkg::SLOT_W;
  localparam int          IDX_W       = satcc_pkg::CFG_IDX_W;
  localparam int          DATA_W      = satcc_pkg::CFG_DATA_W;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {
    ACT_BEAT,
    ACT_REG
  } act_kind_t;

  typedef struct {
    act_kind_t             kind;
    satcc_pkg::satcc_in_t  beat;
    logic [IDX_W-1:0]      reg_idx;
    logic [DATA_W-1:0]     reg_val;
    int unsigned           gap;   // idle cycles after the beat is taken
  } pending_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  satcc_pkg::satcc_in_t  in_data   = '0;
  logic                  cfg_we    = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [DATA_W-1:0]     cfg_wdata = '0;
  logic                  busy;
  logic                  out_valid;
  satcc_pkg::satcc_out_t out_data;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  sat_clause_checker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  pending_t                 todo_q[$];     // beats and register writes still to send
  satcc_pkg::satcc_out_t    verdict_q[$];  // predicted result beats, oldest first
  satcc_pkg::satcc_clause_t clause_copy[SLOTS];
  logic [VAR_W-1:0] reg_vars    = satcc_pkg::VAR_COUNT_RST;
  logic [CNT_W-1:0] reg_clauses = satcc_pkg::CLAUSE_COUNT_RST;
  logic           in_taken = 1'b0;  // input beat accepted at the last rising edge
  int unsigned    gap_left = 0;
  int unsigned    err_cnt  = 0;
  int unsigned    cyc      = 0;
  int unsigned    stall_cyc = 0;
  int unsigned    n_load = 0, n_eval = 0, n_eval_all = 0;
  int unsigned    n_search = 0, n_hit = 0, n_unused = 0, n_reg = 0;

  // Register values as the stimulus generator sees them, in queue order
  logic [VAR_W-1:0] gen_vars    = satcc_pkg::VAR_COUNT_RST;
  logic [CNT_W-1:0] gen_clauses = satcc_pkg::CLAUSE_COUNT_RST;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // A literal reads bit v of the mask; indexes past the mask width read 0.
  function automatic logic lit_ok(logic [VAR_W-1:0] v, logic neg,
                                  logic [SOL_W-1:0] bits);
    logic b;
    b = 1'b0;
    if (v < SOL_W) b = bits[v];
    return b ^ neg;
  endfunction

  function automatic int unsigned count_true(logic [SOL_W-1:0] bits,
                                             int unsigned live);
    int unsigned hits;
    int unsigned c;
    hits = 0;
    for (c = 0; c < live; c++) begin
      if (lit_ok(clause_copy[c].var_first,  clause_copy[c].neg_first,  bits) |
          lit_ok(clause_copy[c].var_second, clause_copy[c].neg_second, bits) |
          lit_ok(clause_copy[c].var_third,  clause_copy[c].neg_third,  bits))
        hits++;
    end
    return hits;
  endfunction

  function automatic satcc_pkg::satcc_out_t predict_verdict(satcc_pkg::satcc_in_t b);
    satcc_pkg::satcc_out_t v;
    int unsigned live, width, top, m, hits;
    v     = '0;
    // Saturate both registers the way the block does
    live  = (32'(reg_clauses) > SLOTS) ? SLOTS : 32'(reg_clauses);
    width = (32'(reg_vars) > VAR_LIMIT) ? VAR_LIMIT : 32'(reg_vars);
    if (width > SOL_W) width = SOL_W;
    top   = (32'd1 << width) - 1;
    if (b.mode == satcc_pkg::MODE_EVAL) begin
      hits              = count_true(b.assignment, live);
      v.satisfied_count = hits[CNT_W-1:0];
      v.all_satisfied   = (hits == live);
      v.solution        = b.assignment;
    end else if (b.mode == satcc_pkg::MODE_SEARCH) begin
      // Walk upward from the start mask; a start past the top finds nothing
      for (m = 32'(b.assignment); m <= top; m++) begin
        if (count_true(m[SOL_W-1:0], live) == live) begin
          v.satisfied_count = live[CNT_W-1:0];
          v.all_satisfied   = 1'b1;
          v.solution        = m[SOL_W-1:0];
          break;
        end
      end
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic satcc_pkg::satcc_in_t noise_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(satcc_pkg::satcc_in_t)-1:0];
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned draw_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // Keep most literals on variables in use, a few anywhere in the 5-bit range
  function automatic logic [VAR_W-1:0] rand_var(int unsigned span);
    if ($urandom_range(4, 0) != 0) return VAR_W'($urandom_range(span - 1, 0));
    return VAR_W'($urandom_range(31, 0));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1, 0));
  endfunction

  task automatic push_beat(satcc_pkg::satcc_in_t b, int unsigned gap);
    pending_t p;
    p.kind    = ACT_BEAT;
    p.beat    = b;
    p.reg_idx = '0;
    p.reg_val = '0;
    p.gap     = gap;
    todo_q.push_back(p);
  endtask

  task automatic push_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    pending_t p;
    p.kind    = ACT_REG;
    p.beat    = '0;
    p.reg_idx = idx;
    p.reg_val = val;
    p.gap     = 0;
    todo_q.push_back(p);
    if (idx == satcc_pkg::CFG_VAR_COUNT) gen_vars = val[VAR_W-1:0];
    else gen_clauses = val;
  endtask

  // Evaluate, search or unused-mode beat; the other fields carry noise
  task automatic ask(logic [MODE_W-1:0] mode, logic [SOL_W-1:0] mask,
                     int unsigned gap);
    satcc_pkg::satcc_in_t b;
    b            = noise_beat();
    b.mode       = mode;
    b.assignment = mask;
    push_beat(b, gap);
  endtask

  task automatic load_clause(logic [SLOT_W-1:0] slot, logic [VAR_W-1:0] va,
                             logic [VAR_W-1:0] vb, logic [VAR_W-1:0] vc,
                             logic na, logic nb, logic nc, int unsigned gap);
    satcc_pkg::satcc_in_t b;
    b             = noise_beat();
    b.mode        = satcc_pkg::MODE_LOAD;
    b.clause_slot = slot;
    b.var_first   = va;
    b.var_second  = vb;
    b.var_third   = vc;
    b.neg_first   = na;
    b.neg_second  = nb;
    b.neg_third   = nc;
    push_beat(b, gap);
  endtask

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge, one assignment per signal
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    logic                  nx_start, nx_we;
    satcc_pkg::satcc_in_t  nx_beat;
    logic [IDX_W-1:0]      nx_idx;
    logic [DATA_W-1:0]     nx_val;
    logic [63:0]           junk;
    pending_t              head;
    // Idle lines carry noise so nothing leans on their value
    junk     = {$urandom, $urandom};
    nx_start = 1'b0;
    nx_we    = 1'b0;
    nx_beat  = junk[$bits(satcc_pkg::satcc_in_t)-1:0];
    nx_idx   = junk[63 -: IDX_W];
    nx_val   = junk[62 -: DATA_W];
    if (rst_n) begin
      if (start && !in_taken) begin
        // Hold the beat until the block takes it
        nx_start = 1'b1;
        nx_beat  = in_data;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (todo_q.size() != 0) begin
        head = todo_q[0];
        if (head.kind == ACT_BEAT) begin
          void'(todo_q.pop_front());
          nx_start = 1'b1;
          nx_beat  = head.beat;
          gap_left = head.gap;
        end else if (verdict_q.size() == 0) begin
          // Write registers only once every result has come back
          void'(todo_q.pop_front());
          nx_we  = 1'b1;
          nx_idx = head.reg_idx;
          nx_val = head.reg_val;
        end
      end
    end
    start     <= nx_start;
    in_data   <= nx_beat;
    cfg_we    <= nx_we;
    cfg_index <= nx_idx;
    cfg_wdata <= nx_val;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge, check results, then predict
  // --------------------------------------------------------------------------
  task automatic flag_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    satcc_pkg::satcc_out_t    want;
    satcc_pkg::satcc_clause_t cl;
    if (!rst_n) begin
      in_taken    <= 1'b0;
      reg_vars    = satcc_pkg::VAR_COUNT_RST;
      reg_clauses = satcc_pkg::CLAUSE_COUNT_RST;
    end else begin
      in_taken <= start && !busy;
      // Match the result beat against the oldest prediction
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing expected, expected none, actual %p",
                   $time, out_data);
        end else begin
          want = verdict_q.pop_front();
          flag_field("satisfied_count", 32'(want.satisfied_count),
                     32'(out_data.satisfied_count));
          flag_field("all_satisfied", 32'(want.all_satisfied),
                     32'(out_data.all_satisfied));
          flag_field("solution", 32'(want.solution), 32'(out_data.solution));
        end
      end
      if (cfg_we) begin
        n_reg++;
        if (cfg_index == satcc_pkg::CFG_VAR_COUNT) reg_vars = cfg_wdata[VAR_W-1:0];
        else if (cfg_index == satcc_pkg::CFG_CLAUSE_COUNT) reg_clauses = cfg_wdata;
      end
      // Predict from the table as it stood before this beat, then apply a load
      if (start && !busy) begin
        want = predict_verdict(in_data);
        verdict_q.push_back(want);
        case (in_data.mode)
          satcc_pkg::MODE_LOAD: begin
            n_load++;
            cl.var_first   = in_data.var_first;
            cl.var_second  = in_data.var_second;
            cl.var_third   = in_data.var_third;
            cl.neg_first   = in_data.neg_first;
            cl.neg_second  = in_data.neg_second;
            cl.neg_third   = in_data.neg_third;
            clause_copy[in_data.clause_slot] = cl;
          end
          satcc_pkg::MODE_EVAL: begin
            n_eval++;
            if (want.all_satisfied) n_eval_all++;
          end
          satcc_pkg::MODE_SEARCH: begin
            n_search++;
            if (want.all_satisfied) n_hit++;
          end
          default: n_unused++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no beat of any kind moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : dog
    cyc <= cyc + 1;
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cyc <= 0;
    end else if (stall_cyc == STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim
    int unsigned order[SLOTS];
    int unsigned i, j, t, ph, n, r, width, top, live, k_max, span;
    logic [SOL_W-1:0] mask;
    bit quiet;
    logic [DATA_W-1:0] val;

    // Directed: no clauses yet, so every mask in range satisfies
    ask(satcc_pkg::MODE_SEARCH, 20'h00000, draw_gap(0));
    ask(satcc_pkg::MODE_SEARCH, 20'hFFFFF, draw_gap(0));
    ask(satcc_pkg::MODE_EVAL,   20'hABCDE, draw_gap(0));
    ask(MODE_UNUSED,            20'hFFFFF, draw_gap(0));
    // Small table: plain, all negated, out-of-range indexes, a tautology
    load_clause(7'd0,   5'd0,  5'd1,  5'd2,  1'b0, 1'b0, 1'b0, draw_gap(0));
    load_clause(7'd1,   5'd19, 5'd18, 5'd17, 1'b1, 1'b1, 1'b1, draw_gap(0));
    load_clause(7'd2,   5'd31, 5'd20, 5'd0,  1'b0, 1'b0, 1'b1, draw_gap(0));
    load_clause(7'd3,   5'd31, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, draw_gap(0));
    load_clause(7'd127, 5'd31, 5'd19, 5'd31, 1'b0, 1'b0, 1'b0, draw_gap(0));
    push_reg(satcc_pkg::CFG_CLAUSE_COUNT, 8'd4);
    ask(satcc_pkg::MODE_EVAL,   20'h00000, draw_gap(0));
    ask(satcc_pkg::MODE_EVAL,   20'hFFFFF, draw_gap(0));
    ask(satcc_pkg::MODE_EVAL,   20'h00001, draw_gap(0));
    ask(satcc_pkg::MODE_EVAL,   20'h00002, draw_gap(0));
    ask(satcc_pkg::MODE_SEARCH, 20'h00000, draw_gap(0));
    // One variable: nothing fits, and a start past the top
    push_reg(satcc_pkg::CFG_VAR_COUNT, 8'd1);
    ask(satcc_pkg::MODE_SEARCH, 20'h00000, draw_gap(0));
    ask(satcc_pkg::MODE_SEARCH, 20'h00002, draw_gap(0));
    // Too many variables saturates; the top sixteen masks all fail
    push_reg(satcc_pkg::CFG_VAR_COUNT, 8'd31);
    ask(satcc_pkg::MODE_SEARCH, 20'hFFFF0, draw_gap(0));
    // No variables and no clauses: only mask zero exists
    push_reg(satcc_pkg::CFG_CLAUSE_COUNT, 8'd0);
    push_reg(satcc_pkg::CFG_VAR_COUNT, 8'd0);
    ask(satcc_pkg::MODE_SEARCH, 20'h00000, draw_gap(0));
    ask(satcc_pkg::MODE_SEARCH, 20'h00001, draw_gap(0));
    ask(satcc_pkg::MODE_EVAL,   20'hFFFFF, draw_gap(0));

    // Fill every slot once in shuffled order so any clause count is safe
    for (i = 0; i < SLOTS; i++) order[i] = i;
    for (i = SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(i, 0);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < SLOTS; i++)
      load_clause(order[i][SLOT_W-1:0], rand_var(8), rand_var(8), rand_var(8),
                  rand_bit(), rand_bit(), rand_bit(), draw_gap(0));

    // Random phases, each under its own register setting
    for (ph = 0; ph < 14; ph++) begin
      quiet = (ph % 5 == 2);
      case (ph)
        0: val = 8'd0;
        1: val = 8'd31;
        2: val = 8'd1;
        3: val = 8'd20;
        default: begin
          if ($urandom_range(2, 0) != 0) val = DATA_W'($urandom_range(8, 2));
          else val = DATA_W'($urandom_range(31, 0));
          // Upper data bits are not part of the register
          if ($urandom_range(1, 0) != 0)
            val[DATA_W-1:VAR_W] = (DATA_W-VAR_W)'($urandom);
        end
      endcase
      push_reg(satcc_pkg::CFG_VAR_COUNT, val);
      case (ph)
        0: val = 8'd255;
        1: val = 8'd0;
        2: val = 8'd128;
        3: val = 8'd129;
        default: begin
          r = $urandom_range(3, 0);
          if (r == 0)      val = DATA_W'($urandom_range(6, 1));
          else if (r == 1) val = DATA_W'($urandom_range(40, 7));
          else if (r == 2) val = DATA_W'($urandom_range(128, 41));
          else             val = DATA_W'($urandom_range(255, 0));
        end
      endcase
      push_reg(satcc_pkg::CFG_CLAUSE_COUNT, val);

      width = (32'(gen_vars) > VAR_LIMIT) ? VAR_LIMIT : 32'(gen_vars);
      top   = (32'd1 << width) - 1;
      live  = (32'(gen_clauses) > SLOTS) ? SLOTS : 32'(gen_clauses);
      span  = (width == 0) ? 1 : width;
      // Bound the masks a search may try so no single beat runs long
      k_max = SEARCH_COST / (live + 2);
      if (k_max > top) k_max = top;

      for (n = 0; n < 130; n++) begin
        r = $urandom_range(99, 0);
        if (r < 25) begin
          load_clause(SLOT_W'($urandom_range(SLOTS - 1, 0)), rand_var(span),
                      rand_var(span), rand_var(span), rand_bit(), rand_bit(),
                      rand_bit(), draw_gap(quiet));
        end else if (r < 60) begin
          mask = SOL_W'($urandom);
          if (r < 28) mask = '0;
          else if (r < 31) mask = '1;
          ask(satcc_pkg::MODE_EVAL, mask, draw_gap(quiet));
        end else if (r < 95) begin
          t = $urandom_range(9, 0);
          if (t == 0 && top < 32'hFFFFF) mask = SOL_W'($urandom_range(32'hFFFFF, top + 1));
          else if (t == 1) mask = top[SOL_W-1:0];
          else mask = SOL_W'(top - $urandom_range(k_max, 0));
          ask(satcc_pkg::MODE_SEARCH, mask, draw_gap(quiet));
        end else begin
          ask(MODE_UNUSED, SOL_W'($urandom), draw_gap(quiet));
        end
      end
    end

    // Release reset on a falling edge, after the stimulus is queued
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent, every result back, then watch for strays
    while (todo_q.size() != 0 || start || verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d clause loads, %0d evaluations (%0d fully satisfied),",
             n_load, n_eval, n_eval_all);
    $display("%0d searches (%0d hits), %0d unused-mode beats, %0d register writes, %0d cycles",
             n_search, n_hit, n_unused, n_reg, cyc);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/satcc_pkg.sv
sv/satcc_ram.sv
sv/sat_clause_checker.sv
bench/tb.sv
